// ===== rtl/slot_bitmap_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLOT_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define SLOT_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SBA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sba assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define SBA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sba assertion failed: next-cycle implication");
`else
`define SBA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SBA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator package
// Field widths, opcodes, status codes and register indexes.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int OPCODE_W   = 2;
  localparam int SLOT_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int LIMIT_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int MAP_WORD_W = 32;
  localparam int BIT_POS_W  = 5;
  localparam int WORD_SEL_W = 3;

  localparam logic [OPCODE_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT     = 1'd1;

  typedef struct packed {
    logic                 hit;
    logic [BIT_POS_W-1:0] pos;
  } ffs_result_t;

endpackage

// ===== rtl/sba_in_if.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface sba_in_if;
  logic                          valid;
  logic                          ready;
  logic [sba_pkg::OPCODE_W-1:0]  opcode;
  logic [sba_pkg::SLOT_W-1:0]    slot_index;

  modport source (output valid, output opcode, output slot_index, input ready);
  modport sink (input valid, input opcode, input slot_index, output ready);
endinterface

// ===== rtl/sba_out_if.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface sba_out_if;
  logic                          valid;
  logic                          ready;
  logic [sba_pkg::STATUS_W-1:0]  status;
  logic [sba_pkg::SLOT_W-1:0]    granted_slot;

  modport source (output valid, output status, output granted_slot, input ready);
  modport sink (input valid, input status, input granted_slot, output ready);
endinterface

// ===== rtl/sba_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator configuration channel
// Valid/ready register write channel carrying an index and write data.
// ----------------------------------------------------------------------------
interface sba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sba_pkg::CFG_IDX_W-1:0]   index;
  logic [sba_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sba_ffs.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator find-first-set unit
// Reports the lowest set bit of a masked 32-bit free map word.
// ----------------------------------------------------------------------------
module sba_ffs (
  input  logic [sba_pkg::MAP_WORD_W-1:0] word_in,
  input  logic [sba_pkg::MAP_WORD_W-1:0] mask_in,
  output sba_pkg::ffs_result_t           result
);

  logic [sba_pkg::MAP_WORD_W-1:0] masked;

  assign masked = word_in & mask_in;

  // Walk from the top down so the lowest set bit is the last one to land.
  always_comb begin
    result = '0;
    for (int i = sba_pkg::MAP_WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        result.hit = 1'b1;
        result.pos = sba_pkg::BIT_POS_W'(i);
      end
    end
  end

endmodule

// ===== rtl/slot_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap allocator
// Per-channel free bitmap with lowest-free-slot allocate, release and
// mark-all-free requests, scanned one 32-bit map word per cycle.
// ----------------------------------------------------------------------------
//
//   channel   dir   word contents                  accepted when
//   -------   ---   ----------------------------   ------------------------
//   in_chan   in    opcode, slot_index             in valid && in ready
//   out_chan  out   status, granted_slot           out valid && out ready
//   cfg_chan  in    index, data                    cfg valid && cfg ready
//
// An allocate scans map words upward to the one holding the limit and stops at
// the first free slot; one find-first-set unit and one map read port set that
// pace. A release in range passes through a release state; other requests
// answer from idle. After reset every slot is free at once: a map word whose
// valid bit is clear reads as all ones, so no clearing pass runs. A result
// word that waits on the receiver holds off the next request until it is taken.
//
module slot_bitmap_allocator_unit #(
  parameter int CHANNELS = 2,
  parameter int SLOTS    = 256
) (
  input logic     clk,
  input logic     rst_n,
  sba_in_if.sink    in_chan,
  sba_out_if.source out_chan,
  sba_cfg_if.sink   cfg_chan
);

  `include "slot_bitmap_allocator_unit_macros.svh"

  localparam int WORDS_PER_CH = (SLOTS + 31) / 32;
  localparam int MAP_WORDS    = CHANNELS * WORDS_PER_CH;
  localparam int AW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  // Grants are limited by the slot count and by the 8-bit result field.
  localparam int LIM_CAP      = (SLOTS < 256) ? SLOTS : 256;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL
  } state_t;

  localparam int WW = sba_pkg::MAP_WORD_W;
  localparam int LW = sba_pkg::LIMIT_W;
  localparam int KW = sba_pkg::WORD_SEL_W;

  // Configuration registers.
  logic                      chan_sel_r;
  logic [LW-1:0]             slot_limit_r;

  // Sequencer state.
  state_t                    state_r;
  logic [AW-1:0]             base_r;
  logic [LW-1:0]             lim_r;
  logic [KW-1:0]             k_r;
  logic [KW-1:0]             last_k_r;
  logic [sba_pkg::SLOT_W-1:0] idx_r;

  // Result register.
  logic                      out_valid_r;
  logic [sba_pkg::STATUS_W-1:0] out_status_r;
  logic [sba_pkg::SLOT_W-1:0]   out_slot_r;

  // Free map storage.
  logic [WW-1:0]             map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]      map_valid_r;
  logic [WW-1:0]             rd_data_r;
  logic                      rd_vld_r;

  logic                      in_accept;
  logic                      free_all_accept;
  logic [LW-1:0]             eff_lim;
  logic [LW-1:0]             eff_lim_m1;
  logic [AW-1:0]             acc_base;
  logic [KW-1:0]             acc_word_sel;
  logic [AW-1:0]             rd_addr;
  logic [WW-1:0]             word_cur;
  logic [WW-1:0]             scan_mask;
  sba_pkg::ffs_result_t      ffs_res;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [WW-1:0]             wr_data;

  // ---------------------------------------------------------------------------
  // Handshakes and request decode
  // ---------------------------------------------------------------------------
  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign free_all_accept = in_accept && (in_chan.opcode == sba_pkg::OP_FREE_ALL);

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.granted_slot = out_slot_r;

  // Register writes are to be issued only while the block is idle; the block
  // does not enforce this and always takes them.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r   <= 1'b0;
      slot_limit_r <= LW'(256);
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        sba_pkg::REG_CHANNEL_SELECT: chan_sel_r   <= cfg_chan.data[0];
        sba_pkg::REG_SLOT_LIMIT:     slot_limit_r <= cfg_chan.data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The usable limit is clamped to the slots that exist. A channel select
  // past the channel count wraps, which with one channel means channel zero.
  assign eff_lim    = (slot_limit_r > LW'(LIM_CAP)) ? LW'(LIM_CAP) : slot_limit_r;
  assign eff_lim_m1 = eff_lim - LW'(1);
  assign acc_base   = (CHANNELS > 1 && chan_sel_r) ? AW'(WORDS_PER_CH) : '0;

  assign acc_word_sel = (in_chan.opcode == sba_pkg::OP_ALLOC) ? '0 :
                        in_chan.slot_index[7:5];

  // ---------------------------------------------------------------------------
  // Map read path: while scanning, the next word is fetched while the
  // current one is examined.
  // ---------------------------------------------------------------------------
  assign rd_addr = (state_r == S_IDLE) ? (acc_base + AW'(acc_word_sel)) :
                   (base_r + AW'(k_r + KW'(1)));

  assign word_cur = rd_vld_r ? rd_data_r : '1;

  // Only the last word of the scan can straddle the limit.
  always_comb begin
    scan_mask = '1;
    if (k_r == last_k_r && lim_r[4:0] != 5'd0) begin
      scan_mask = (WW'(1) << lim_r[4:0]) - WW'(1);
    end
  end

  sba_ffs u_ffs (
    .word_in (word_cur),
    .mask_in (scan_mask),
    .result  (ffs_res)
  );

  // ---------------------------------------------------------------------------
  // Map write path: a grant clears one bit, a release sets one.
  // ---------------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = base_r + AW'(k_r);
    wr_data = word_cur & ~(WW'(1) << ffs_res.pos);
    case (state_r)
      S_SCAN: begin
        wr_en = ffs_res.hit;
      end
      S_REL: begin
        wr_en   = 1'b1;
        wr_addr = base_r + AW'(idx_r[7:5]);
        wr_data = word_cur | (WW'(1) << idx_r[4:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= map_mem[rd_addr];
    rd_vld_r  <= map_valid_r[rd_addr];
  end

  // A word without its valid bit reads as all free, so mark-all-free clears
  // these bits all at once, for every channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
    end else if (free_all_accept) begin
      map_valid_r <= '0;
    end else if (wr_en) begin
      map_valid_r[wr_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  // A request is only taken when the result register is empty or being
  // emptied, so it stays empty for as long as the request is busy and only
  // the idle state has to drain it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            base_r   <= acc_base;
            lim_r    <= eff_lim;
            idx_r    <= in_chan.slot_index;
            k_r      <= '0;
            last_k_r <= eff_lim_m1[7:5];
            case (in_chan.opcode)
              sba_pkg::OP_ALLOC: begin
                if (eff_lim == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= sba_pkg::ST_NONE_FREE;
                  out_slot_r   <= '0;
                end else begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_SCAN;
                end
              end
              sba_pkg::OP_RELEASE: begin
                if ({1'b0, in_chan.slot_index} >= eff_lim) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= sba_pkg::ST_RANGE;
                  out_slot_r   <= '0;
                end else begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_REL;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= sba_pkg::ST_OK;
                out_slot_r   <= '0;
              end
            endcase
          end else if (out_chan.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (ffs_res.hit) begin
            out_valid_r  <= 1'b1;
            out_status_r <= sba_pkg::ST_OK;
            out_slot_r   <= {k_r, ffs_res.pos};
            state_r      <= S_IDLE;
          end else if (k_r == last_k_r) begin
            out_valid_r  <= 1'b1;
            out_status_r <= sba_pkg::ST_NONE_FREE;
            out_slot_r   <= '0;
            state_r      <= S_IDLE;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_REL: begin
          out_valid_r  <= 1'b1;
          out_status_r <= sba_pkg::ST_OK;
          out_slot_r   <= '0;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SBA_ASSERT_IMP(a_scan_in_bounds, clk, rst_n, state_r == S_SCAN, k_r <= last_k_r)
  `SBA_ASSERT_IMP(a_write_only_busy, clk, rst_n, wr_en,
                  (state_r == S_SCAN || state_r == S_REL))
  `SBA_ASSERT_NXT(a_grant_below_limit, clk, rst_n, (state_r == S_SCAN && ffs_res.hit),
                  (out_valid_r && {1'b0, out_slot_r} < lim_r))
  `SBA_ASSERT_NXT(a_alloc_starts_scan, clk, rst_n,
                  (in_accept && in_chan.opcode == sba_pkg::OP_ALLOC && eff_lim != '0),
                  state_r == S_SCAN)
  `SBA_ASSERT_IMP(a_busy_no_result, clk, rst_n, state_r != S_IDLE, !out_valid_r)

endmodule

// ===== bench/tb_slot_bitmap_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot bitmap allocator testbench
// Drives allocate, release, mark-all-free and reserved-opcode requests, with register writes
// between phases, and checks every result word against a cycle-free
// prediction of the per-channel free bitmaps.
// ----------------------------------------------------------------------------
module tb_slot_bitmap_allocator_unit;

  localparam int CHANNELS = 2;
  localparam int SLOTS    = 256;

  // The package has no name for the fourth opcode. The block must answer it
  // like a no-op, so it gets a name of its own here.
  localparam logic [sba_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;

  // Run shape. The watchdog limit has to cover the long receiver hold-off
  // plus the worst scan, so it is set well above both.
  localparam int ITEM_TARGET  = 1150;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic [sba_pkg::STATUS_W-1:0] status;
    logic [sba_pkg::SLOT_W-1:0]   slot;
  } grant_t;

  // Scoreboard: keeps its own copy of both free bitmaps and both registers,
  // predicts the result word of each accepted request and checks the result
  // words in arrival order.
  class free_slot_scoreboard;
    logic [SLOTS-1:0]              free_bits [CHANNELS];
    logic                          chan_sel;
    logic [sba_pkg::LIMIT_W-1:0]   slot_limit;
    grant_t                        awaited_grants [$];
    int                            fail_count;

    function new();
      mark_all_free();
      chan_sel   = 1'b0;
      slot_limit = 9'd256;
      fail_count = 0;
    endfunction

    function void mark_all_free();
      for (int c = 0; c < CHANNELS; c++) free_bits[c] = '1;
    endfunction

    // The limit is capped by the number of slots and by what granted_slot
    // can carry. A limit of zero means no slot exists.
    function int usable_slots();
      int lim;
      lim = slot_limit;
      if (lim > SLOTS) lim = SLOTS;
      if (lim > 256) lim = 256;
      return lim;
    endfunction

    function int active_channel();
      return int'(chan_sel) % CHANNELS;
    endfunction

    function void write_reg(logic [sba_pkg::CFG_IDX_W-1:0] idx,
                            logic [sba_pkg::CFG_DATA_W-1:0] data);
      if (idx == sba_pkg::REG_CHANNEL_SELECT) chan_sel = data[0];
      else slot_limit = data[sba_pkg::LIMIT_W-1:0];
    endfunction

    function void note_request(logic [sba_pkg::OPCODE_W-1:0] op,
                               logic [sba_pkg::SLOT_W-1:0] idx);
      grant_t r;
      int     ch;
      int     lim;
      ch       = active_channel();
      lim      = usable_slots();
      r.status = sba_pkg::ST_OK;
      r.slot   = '0;
      case (op)
        sba_pkg::OP_ALLOC: begin
          // Lowest free slot below the limit; free bits above it never count.
          r.status = sba_pkg::ST_NONE_FREE;
          for (int s = 0; s < lim; s++) begin
            if (free_bits[ch][s]) begin
              free_bits[ch][s] = 1'b0;
              r.status = sba_pkg::ST_OK;
              r.slot   = sba_pkg::SLOT_W'(s);
              break;
            end
          end
        end
        sba_pkg::OP_RELEASE: begin
          if (idx >= lim) r.status = sba_pkg::ST_RANGE;
          else free_bits[ch][idx] = 1'b1;
        end
        sba_pkg::OP_FREE_ALL: begin
          mark_all_free();
        end
        default: begin
        end
      endcase
      awaited_grants.push_back(r);
    endfunction

    function void check_result(logic [sba_pkg::STATUS_W-1:0] status,
                               logic [sba_pkg::SLOT_W-1:0] slot);
      grant_t want;
      if (awaited_grants.size() == 0) begin
        $error("unexpected result word: status %0d granted_slot %0d", status, slot);
        fail_count++;
        return;
      end
      want = awaited_grants.pop_front();
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        fail_count++;
      end
      if (slot !== want.slot) begin
        $error("granted_slot mismatch: expected %0d, actual %0d", want.slot, slot);
        fail_count++;
      end
    endfunction

    // A slot of the active channel that is currently taken, or -1. Used to
    // make most releases hit slots that were really granted.
    function int busy_slot();
      int ch;
      int lim;
      int start;
      ch  = active_channel();
      lim = usable_slots();
      if (lim == 0) return -1;
      start = $urandom_range(lim - 1, 0);
      for (int k = 0; k < lim; k++) begin
        if (!free_bits[ch][(start + k) % lim]) return (start + k) % lim;
      end
      return -1;
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sba_in_if  in_chan ();
  sba_out_if out_chan ();
  sba_cfg_if cfg_chan ();

  free_slot_scoreboard board = new();

  // Shared between the request side and the result side. All of these are
  // written right after a rising edge and read at falling edges, so the two
  // processes never race on them.
  int sent_count;
  bit calm;
  int idle_pct;
  bit pressure_armed;

  // Slot limits for the first phases; the second, the fill phase, gets 256.
  int limit_picks [12] = '{33, 256, 1, 64, 0, 511, 32, 255, 257, 2, 31, 100};

  slot_bitmap_allocator_unit #(
    .CHANNELS(CHANNELS),
    .SLOTS   (SLOTS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #2 clk = ~clk;

  // Result words are taken at the rising edge, where they are stable since
  // the testbench only moves its own signals at falling edges.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      board.check_result(out_chan.status, out_chan.granted_slot);
    end
  end

  // Offers one request word and holds it until the block takes it. The valid
  // stays high afterwards, so back-to-back words need no extra edge.
  task automatic send_request(logic [sba_pkg::OPCODE_W-1:0] op,
                              logic [sba_pkg::SLOT_W-1:0] idx);
    @(negedge clk);
    in_chan.valid      = 1'b1;
    in_chan.opcode     = op;
    in_chan.slot_index = idx;
    do @(posedge clk); while (!in_chan.ready);
    board.note_request(op, idx);
    sent_count++;
  endtask

  // Drops valid for a number of cycles and scrambles the idle payload, which
  // the block must ignore.
  task automatic sender_gap(int cycles);
    @(negedge clk);
    in_chan.valid      = 1'b0;
    in_chan.opcode     = sba_pkg::OPCODE_W'($urandom);
    in_chan.slot_index = sba_pkg::SLOT_W'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic write_reg(logic [sba_pkg::CFG_IDX_W-1:0] idx,
                           logic [sba_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = data;
    do @(posedge clk); while (!cfg_chan.ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Stops offering requests and waits until every predicted result word has
  // come back, then lets the block drain. Registers are only
  // written after this.
  task automatic settle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (board.awaited_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One phase of random requests under the current register setting.
  // Releases mostly name slots that are really taken, so that allocations
  // keep finding holes in the middle of the map; the rest are random and
  // may fall out of range. A small share is mark-all-free or the reserved
  // opcode.
  task automatic random_phase(int count, int alloc_pct, int noise_pct, bit with_hold);
    logic [sba_pkg::OPCODE_W-1:0] op;
    logic [sba_pkg::SLOT_W-1:0]   idx;
    int                           roll;
    int                           busy;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99, 0);
      idx  = sba_pkg::SLOT_W'($urandom_range(255, 0));
      if (roll < alloc_pct) begin
        op = sba_pkg::OP_ALLOC;
      end else if (roll < 100 - noise_pct) begin
        op   = sba_pkg::OP_RELEASE;
        busy = board.busy_slot();
        if (busy >= 0 && $urandom_range(3, 0) != 0) idx = sba_pkg::SLOT_W'(busy);
      end else begin
        op = $urandom_range(1, 0) ? sba_pkg::OP_FREE_ALL : OP_RESERVED;
      end
      send_request(op, idx);
      // Ask the result side for its long hold-off once the phase is running,
      // so the sender keeps pushing into a full block.
      if (with_hold && k == 4) pressure_armed = 1'b1;
      if (!calm && $urandom_range(99, 0) < idle_pct) sender_gap($urandom_range(11, 1));
    end
  endtask

  // Result side: ready drops in random bursts, once for a long hold-off on
  // request, and never in the calm tail of the run.
  initial begin : result_sink
    int hold;
    hold           = 0;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (pressure_armed) begin
        pressure_armed = 1'b0;
        hold           = LONG_HOLD - 1;
        out_chan.ready = 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else if (!calm && $urandom_range(99, 0) < idle_pct / 2) begin
        hold           = $urandom_range(10, 0);
        out_chan.ready = 1'b0;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int                             phase;
    int                             lim;
    logic [sba_pkg::CFG_DATA_W-1:0] cfg_word;
    phase              = 0;
    sent_count         = 0;
    calm               = 1'b0;
    idle_pct           = 0;
    pressure_armed     = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.opcode     = '0;
    in_chan.slot_index = '0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = '0;
    cfg_chan.data      = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, at the reset setting: channel 0, all 256 slots.
    // Two grants from an empty map, a release, a release of a slot that is
    // already free, a re-grant of the lowest hole, a release at the top of
    // the index range, the reserved opcode with a busy payload and a
    // mark-all-free with the opposite payload, then a grant.
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    send_request(sba_pkg::OP_ALLOC, 8'hff);
    send_request(sba_pkg::OP_RELEASE, 8'h00);
    send_request(sba_pkg::OP_RELEASE, 8'h00);
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    send_request(sba_pkg::OP_RELEASE, 8'hff);
    send_request(OP_RESERVED, 8'haa);
    send_request(sba_pkg::OP_FREE_ALL, 8'h55);
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    settle();

    // Channel 1 through a write with junk in the upper data bits, and a
    // single usable slot: one grant, then nothing free, then releases on
    // and above the limit, and one of the granted slot.
    write_reg(sba_pkg::REG_CHANNEL_SELECT, 9'h1fe | 9'h001);
    write_reg(sba_pkg::REG_SLOT_LIMIT, 9'd1);
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    send_request(sba_pkg::OP_RELEASE, 8'h01);
    send_request(sba_pkg::OP_RELEASE, 8'hff);
    send_request(sba_pkg::OP_RELEASE, 8'h00);
    settle();

    // A limit of zero: no slot exists at all.
    write_reg(sba_pkg::REG_SLOT_LIMIT, 9'd0);
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    send_request(sba_pkg::OP_RELEASE, 8'h00);
    settle();

    // A limit beyond the map size is clamped to 256. Back on channel 0, the
    // map there still holds the grant made after mark-all-free.
    write_reg(sba_pkg::REG_CHANNEL_SELECT, 9'h000);
    write_reg(sba_pkg::REG_SLOT_LIMIT, 9'd511);
    send_request(sba_pkg::OP_ALLOC, 8'h00);
    send_request(sba_pkg::OP_RELEASE, 8'hff);
    send_request(sba_pkg::OP_FREE_ALL, 8'h00);
    send_request(sba_pkg::OP_ALLOC, 8'h00);

    // Random phases. Each one starts from an idle block with a new channel,
    // limit and idling level. Phase 1 fills a whole channel to exhaustion;
    // phase 3 carries the long hold-off on the result side. Later limits
    // are mostly small so that the map runs dry often.
    while (sent_count < ITEM_TARGET) begin
      settle();
      calm = (sent_count >= ITEM_TARGET - CALM_ITEMS);
      case ($urandom_range(2, 0))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (phase < 12) lim = limit_picks[phase];
      else if ($urandom_range(3, 0) == 0) lim = $urandom_range(511, 0);
      else lim = $urandom_range(40, 1);
      cfg_word    = sba_pkg::CFG_DATA_W'($urandom);
      cfg_word[0] = $urandom_range(1, 0);
      write_reg(sba_pkg::REG_CHANNEL_SELECT, cfg_word);
      write_reg(sba_pkg::REG_SLOT_LIMIT, sba_pkg::CFG_DATA_W'(lim));
      if (phase == 1) random_phase(300, 95, 0, 1'b0);
      else random_phase($urandom_range(100, 40), 55, 4, phase == 3);
      phase++;
    end

    settle();
    if (board.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
